// ===== rtl/mtd_pkg.sv =====
// shared types, sizes and register codes of the mask threshold and dilation block
package mtd_pkg;

    // sizing of the window and of the column store
    localparam int MAX_RADIUS = 4;
    localparam int MAX_WIDTH  = 512;
    localparam int HEIGHT_MAX = 1023;

    // register reset values
    localparam logic [7:0] THRESHOLD_RESET = 8'd127;
    localparam logic [2:0] RADIUS_RESET    = 3'd4;
    localparam logic [9:0] WIDTH_RESET     = 10'd512;
    localparam logic [9:0] HEIGHT_RESET    = 10'd512;

    // derived widths
    localparam int HIST_W     = 2 * MAX_RADIUS;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WID_W      = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W      = $clog2(HEIGHT_MAX + MAX_RADIUS + 2);
    localparam int HGT_W      = 10;
    localparam int RAD_W      = $clog2(MAX_RADIUS + 1);
    localparam int SPAN_W     = $clog2(2 * MAX_RADIUS + 1);
    localparam int AGE_W      = SPAN_W;
    localparam int X_W        = $clog2(MAX_WIDTH + 2 * MAX_RADIUS + 1);
    localparam int LAG_W      = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD,
        REG_RADIUS,
        REG_FRAME_WIDTH,
        REG_FRAME_HEIGHT
    } mtd_reg_idx_t;

    // item kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    // input item
    typedef struct packed {
        logic       kind;
        logic [7:0] grey_value;
    } mtd_in_t;

    // result item
    typedef struct packed {
        logic mask_set;
        logic frame_last;
    } mtd_out_t;

    // broadcast to the window cells
    typedef struct packed {
        logic              shift;
        logic [X_W-1:0]    reach;
        logic [X_W-1:0]    width;
        logic [SPAN_W-1:0] span;
    } mtd_win_ctrl_t;

endpackage

// ===== rtl/mtd_col_store.sv =====
// column store: per column the marked bits of the previous rows, one read and one write a cycle
module mtd_col_store
    import mtd_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [COL_W-1:0]  wr_addr,
    input  logic [HIST_W-1:0] wr_data,
    input  logic [COL_W-1:0]  rd_addr,
    output logic [HIST_W-1:0] rd_data
);

    logic [HIST_W-1:0] col_mem [MAX_WIDTH];
    logic [HIST_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            col_mem[wr_addr] <= wr_data;
        end
    end

    // registered read, new data forwarded on an address match
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= col_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/mtd_cell.sv =====
// window cell: holds one column-or bit and folds it into the running window or
module mtd_cell
    import mtd_pkg::*;
(
    input  logic              clk,
    input  mtd_win_ctrl_t     ctrl,
    input  logic [AGE_W-1:0]  age,
    input  logic              bit_in,
    input  logic              or_in,
    output logic              bit_out,
    output logic              or_out
);

    logic bit_reg;
    logic in_window;

    // shift along the chain on every advancing item
    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            bit_reg <= bit_in;
        end
    end

    // age within twice the radius and column inside the output row
    assign in_window = (X_W'(age) <= X_W'(ctrl.span))
                    && (ctrl.reach >= X_W'(age))
                    && (ctrl.reach < (ctrl.width + X_W'(age)));

    assign bit_out = bit_reg;
    assign or_out  = or_in | (bit_reg & in_window);

endmodule

// ===== rtl/mtd_out_buf.sv =====
// two-entry result buffer: output register plus skid register
module mtd_out_buf
    import mtd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  mtd_out_t push_data,
    output logic     space,
    output logic     out_valid,
    input  logic     out_ready,
    output mtd_out_t out_data
);

    logic     head_valid_reg;
    logic     head_valid_next;
    logic     skid_valid_reg;
    logic     skid_valid_next;
    mtd_out_t head_reg;
    mtd_out_t skid_reg;
    logic     pop;

    assign pop = head_valid_reg && out_ready;

    // occupancy
    always_comb
    begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            head_valid_next = 1'b1;
            skid_valid_next = !pop;
        end
        else if (push)
        begin
            head_valid_next = 1'b1;
            skid_valid_next = head_valid_reg && !pop;
        end
        else if (pop)
        begin
            head_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload moves
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg && pop)
        begin
            head_reg <= skid_reg;
        end
        else if (!skid_valid_reg && push && (!head_valid_reg || pop))
        begin
            head_reg <= push_data;
        end
        if (!skid_valid_reg && push && head_valid_reg && !pop)
        begin
            skid_reg <= push_data;
        end
    end

    assign space     = !skid_valid_reg;
    assign out_valid = head_valid_reg;
    assign out_data  = head_reg;

endmodule

// ===== rtl/mask_threshold_dilate_unit.sv =====
// top level of the mask threshold and square dilation block
//
// Grey pixels enter on the pixel channel (valid/ready) in raster order, one
// frame of frame_height rows of frame_width pixels, followed by drain items
// that flush the tail. Each accepted item that reaches past the window lag
// yields one result on the result channel (valid/ready): the dilated mask bit
// and a frame_last flag on the final result of the frame. The result for
// pixel k comes with item k + radius*frame_width + radius and is pushed to the
// result buffer when that item is accepted. One item is accepted every clock
// while the buffer has space; the rate is set by the single read and write
// port of the column store, which is visited once per item. Configuration
// writes on cfg_write/cfg_index/cfg_data take effect at once and restart the
// frame counters. Reset sets the registers to threshold 127, radius 4, 512 by
// 512 frame and empties the result buffer; the column store needs no clearing
// pass, since rows older than the current frame are masked out. When the
// receiver stalls, a two-entry result buffer absorbs one more result and
// pixel_ready drops only while both entries are full.
module mask_threshold_dilate_unit
    import mtd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pixel_valid,
    output logic                  pixel_ready,
    input  mtd_in_t               pixel,
    output logic                  result_valid,
    input  logic                  result_ready,
    output mtd_out_t              result,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [7:0]        threshold_reg;
    logic [2:0]        radius_reg;
    logic [9:0]        frame_width_reg;
    logic [9:0]        frame_height_reg;

    logic [RAD_W-1:0]  r_eff;
    logic [WID_W-1:0]  w_eff;
    logic [HGT_W-1:0]  h_eff;
    logic [SPAN_W-1:0] span;
    logic [LAG_W-1:0]  lag;

    logic [COL_W-1:0]  in_col_reg;
    logic [COL_W-1:0]  in_col_next;
    logic [ROW_W-1:0]  in_row_reg;
    logic [ROW_W-1:0]  in_row_next;
    logic [COL_W-1:0]  out_col_reg;
    logic [COL_W-1:0]  out_col_next;
    logic [HGT_W-1:0]  out_row_reg;
    logic [HGT_W-1:0]  out_row_next;
    logic [LAG_W-1:0]  lead_cnt_reg;
    logic [LAG_W-1:0]  lead_cnt_next;

    logic              accept;
    logic              pixel_phase;
    logic              adv;
    logic              produce;
    logic              frame_done;
    logic              restart;
    logic [WID_W-1:0]  col_inc;
    logic [WID_W-1:0]  out_col_inc;

    logic              mark;
    logic [HIST_W-1:0] hist;
    logic [HIST_W:0]   colvec;
    logic              v_bit;
    logic [X_W-1:0]    reach;
    logic              seed;
    mtd_win_ctrl_t     win_ctrl;
    logic [HIST_W-1:0] cell_bit;
    logic [HIST_W-1:0] cell_or;

    logic              buf_space;
    mtd_out_t          push_data;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= THRESHOLD_RESET;
            radius_reg       <= RADIUS_RESET;
            frame_width_reg  <= WIDTH_RESET;
            frame_height_reg <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (mtd_reg_idx_t'(cfg_index))
                REG_THRESHOLD:    threshold_reg    <= cfg_data[7:0];
                REG_RADIUS:       radius_reg       <= cfg_data[2:0];
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[9:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[9:0];
                default:          threshold_reg    <= threshold_reg;
            endcase
        end
    end

    // effective radius, width and height
    always_comb
    begin
        if (int'(radius_reg) > MAX_RADIUS)
        begin
            r_eff = RAD_W'(MAX_RADIUS);
        end
        else
        begin
            r_eff = RAD_W'(radius_reg);
        end
        if (frame_width_reg == '0)
        begin
            w_eff = WID_W'(1);
        end
        else if (int'(frame_width_reg) > MAX_WIDTH)
        begin
            w_eff = WID_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WID_W'(frame_width_reg);
        end
        if (frame_height_reg == '0)
        begin
            h_eff = HGT_W'(1);
        end
        else
        begin
            h_eff = frame_height_reg;
        end
    end

    assign span = SPAN_W'(r_eff) + SPAN_W'(r_eff);
    assign lag  = LAG_W'(r_eff) * LAG_W'(w_eff) + LAG_W'(r_eff);

    // item classification
    assign accept      = pixel_valid && pixel_ready;
    assign pixel_phase = in_row_reg < ROW_W'(h_eff);
    assign adv         = accept && !((pixel.kind == KIND_DRAIN) && pixel_phase);
    assign produce     = lead_cnt_reg == lag;
    assign frame_done  = produce
                      && (out_row_reg >= (h_eff - HGT_W'(1)))
                      && (WID_W'(out_col_reg) >= (w_eff - WID_W'(1)));
    assign restart     = cfg_write || (adv && frame_done);

    assign col_inc     = WID_W'(in_col_reg) + WID_W'(1);
    assign out_col_inc = WID_W'(out_col_reg) + WID_W'(1);

    // position counters
    always_comb
    begin
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        lead_cnt_next = lead_cnt_reg;
        if (restart)
        begin
            in_col_next   = '0;
            in_row_next   = '0;
            out_col_next  = '0;
            out_row_next  = '0;
            lead_cnt_next = '0;
        end
        else if (adv)
        begin
            if (col_inc >= w_eff)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + ROW_W'(1);
            end
            else
            begin
                in_col_next = COL_W'(col_inc);
            end
            if (!produce)
            begin
                lead_cnt_next = lead_cnt_reg + LAG_W'(1);
            end
            else if (out_col_inc >= w_eff)
            begin
                out_col_next = '0;
                out_row_next = out_row_reg + HGT_W'(1);
            end
            else
            begin
                out_col_next = COL_W'(out_col_inc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            lead_cnt_reg <= '0;
        end
        else
        begin
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            lead_cnt_reg <= lead_cnt_next;
        end
    end

    // threshold, zero for drain and surplus items
    assign mark   = pixel_phase && (pixel.grey_value > threshold_reg);
    assign colvec = {hist, mark};

    // column history, read ahead at the column of the next item
    mtd_col_store u_col_store (
        .clk     (clk),
        .wr_en   (adv),
        .wr_addr (in_col_reg),
        .wr_data (colvec[HIST_W-1:0]),
        .rd_addr (in_col_next),
        .rd_data (hist)
    );

    // vertical or over the rows of this frame within the window
    always_comb
    begin
        v_bit = 1'b0;
        for (int j = 0; j <= HIST_W; j++)
        begin
            if (colvec[j] && (j <= int'(span)) && (j <= int'(in_row_reg)))
            begin
                v_bit = 1'b1;
            end
        end
    end

    // horizontal window along the cell chain
    assign reach = X_W'(out_col_reg) + X_W'(r_eff);
    assign seed  = v_bit && (reach < X_W'(w_eff));

    assign win_ctrl.shift = adv;
    assign win_ctrl.reach = reach;
    assign win_ctrl.width = X_W'(w_eff);
    assign win_ctrl.span  = span;

    for (genvar i = 0; i < HIST_W; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            mtd_cell u_cell (
                .clk     (clk),
                .ctrl    (win_ctrl),
                .age     (AGE_W'(i + 1)),
                .bit_in  (v_bit),
                .or_in   (seed),
                .bit_out (cell_bit[i]),
                .or_out  (cell_or[i])
            );
        end
        else
        begin : g_body
            mtd_cell u_cell (
                .clk     (clk),
                .ctrl    (win_ctrl),
                .age     (AGE_W'(i + 1)),
                .bit_in  (cell_bit[i-1]),
                .or_in   (cell_or[i-1]),
                .bit_out (cell_bit[i]),
                .or_out  (cell_or[i])
            );
        end
    end

    // result buffer
    assign push_data.mask_set   = cell_or[HIST_W-1];
    assign push_data.frame_last = frame_done;

    mtd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (adv && produce),
        .push_data (push_data),
        .space     (buf_space),
        .out_valid (result_valid),
        .out_ready (result_ready),
        .out_data  (result)
    );

    assign pixel_ready = buf_space;

    // end of frame brings every position counter back to the start
    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && frame_done) |=> (in_col_reg == '0 && in_row_reg == '0
                                 && out_col_reg == '0 && out_row_reg == '0
                                 && lead_cnt_reg == '0))
        else $error("counters not cleared after the last result of a frame");

    // the input side stalls only behind a full buffer
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !pixel_ready |-> result_valid)
        else $error("pixel_ready low with no result on offer");

    // column counters stay inside the frame
    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (WID_W'(in_col_reg) < w_eff) && (WID_W'(out_col_reg) < w_eff))
        else $error("column counter outside the frame width");

endmodule
